@@ rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational accumulator unit
// Commands, status codes, request/response structs and the control interface
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned DenWidth  = DataWidth - 1;
  localparam int unsigned WideWidth = 2 * DataWidth + 1;
  localparam int unsigned CntWidth  = $clog2(WideWidth + 1);

  typedef enum logic [2:0] {
    CmdLoad = 3'd0,
    CmdAdd  = 3'd1,
    CmdSub  = 3'd2,
    CmdMul  = 3'd3,
    CmdDiv  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatZero     = 2'd1,
    StatOverflow = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]                  cmd;
    logic signed [DataWidth-1:0] operand_num;
    logic [DenWidth-1:0]         operand_den;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_num;
    logic [DenWidth-1:0]         result_den;
    logic [1:0]                  status;
  } rsp_t;

  typedef struct packed {
    logic load;       // capture request
    logic mul_a;      // first product stage
    logic mul_b;      // second product stage
    logic form;       // form numerator and denominator
    logic gcd_step;   // one Euclid modulo step (bit-serial division)
    logic gcd_next;   // swap after modulo completes
    logic div_start;  // start reduction divisions
    logic div_step;   // one bit of both reductions
    logic commit;     // update state and response
  } ctrl_t;

  typedef struct packed {
    logic skip;       // command finishes without arithmetic
    logic mod_done;   // current modulo finished
    logic gcd_done;   // divisor reached zero
    logic div_done;   // reductions finished
  } stat_t;

endpackage

@@ rtl/rau_datapath.sv @@
// ----------------------------------------------------------------------------
// rau_datapath: accumulator state, products, Euclid and reduction divider
// Wide values are processed one bit a cycle by a restoring divider.
// ----------------------------------------------------------------------------
module rau_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rau_pkg::req_t req_i,
  input  rau_pkg::ctrl_t ctrl_i,
  output rau_pkg::stat_t stat_o,
  output rau_pkg::rsp_t rsp_o
);
  localparam int unsigned DW = rau_pkg::DataWidth;
  localparam int unsigned WW = rau_pkg::WideWidth;
  localparam int unsigned CW = rau_pkg::CntWidth;

  logic signed [DW-1:0]   acc_num_q;
  logic [DW-2:0]          acc_den_q;
  logic [2:0]             cmd_q;
  logic signed [DW:0]     c_q;
  logic signed [DW:0]     d_q;
  logic                   err_q;
  logic signed [2*DW+1:0] p1_q, p2_q, p3_q;
  logic                   neg_q;
  logic [WW-1:0]          mag_q, den_q;
  logic [WW-1:0]          ga_q, gb_q;
  logic [WW-1:0]          quo_q, rem_q, quo2_q, rem2_q;
  logic [CW-1:0]          cnt_q;
  logic [1:0]             status_q;

  logic signed [DW:0]     a_ext, b_ext;
  logic signed [2*DW+1:0] n_w, d_w;
  logic [WW-1:0]          rem_sh, rem2_sh;
  logic [WW-1:0]          lim;

  assign a_ext = {acc_num_q[DW-1], acc_num_q};
  assign b_ext = {2'b00, acc_den_q};
  assign lim   = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};

  always_comb begin
    n_w = p1_q;
    d_w = p3_q;
    case (cmd_q)
      rau_pkg::CmdLoad: begin
        n_w = (2*DW+2)'(c_q);
        d_w = (2*DW+2)'(d_q);
      end
      rau_pkg::CmdAdd: n_w = p1_q + p2_q;
      rau_pkg::CmdSub: n_w = p1_q - p2_q;
      rau_pkg::CmdMul: n_w = p1_q;
      rau_pkg::CmdDiv: begin
        n_w = c_q[DW] ? -p1_q : p1_q;
        d_w = c_q[DW] ? -p3_q : p3_q;
      end
      default: ;
    endcase
  end

  assign rem_sh  = {rem_q[WW-2:0], ga_q[CW'(WW-1) - cnt_q]};
  assign rem2_sh = {rem2_q[WW-2:0], den_q[CW'(WW-1) - cnt_q]};

  assign stat_o.skip     = err_q;
  assign stat_o.mod_done = (cnt_q == CW'(WW));
  assign stat_o.gcd_done = (gb_q == '0);
  assign stat_o.div_done = (cnt_q == CW'(WW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_num_q <= DW'(1);
      acc_den_q <= (DW-1)'(1);
    end else if (ctrl_i.commit && !err_q && cmd_q <= rau_pkg::CmdDiv) begin
      if (quo_q <= lim && quo2_q <= lim) begin
        acc_num_q <= neg_q ? -DW'(quo_q) : DW'(quo_q);
        acc_den_q <= (DW-1)'(quo2_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= req_i.cmd;
      c_q   <= {req_i.operand_num[DW-1], req_i.operand_num};
      d_q   <= {2'b00, req_i.operand_den};
      err_q <= (req_i.cmd > rau_pkg::CmdDiv) || (req_i.operand_den == '0) ||
               (req_i.cmd == rau_pkg::CmdDiv && req_i.operand_num == '0);
    end
    if (ctrl_i.mul_a) begin
      p1_q <= (2*DW+2)'(a_ext * ((cmd_q == rau_pkg::CmdMul) ? c_q : d_q));
    end
    if (ctrl_i.mul_b) begin
      p2_q <= (2*DW+2)'(c_q * b_ext);
      p3_q <= (2*DW+2)'(b_ext * ((cmd_q == rau_pkg::CmdDiv) ? c_q : d_q));
    end
    if (ctrl_i.form) begin
      neg_q <= n_w[2*DW+1];
      mag_q <= WW'(n_w[2*DW+1] ? -n_w : n_w);
      den_q <= WW'(d_w);
      ga_q  <= WW'(n_w[2*DW+1] ? -n_w : n_w);
      gb_q  <= WW'(d_w);
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (ctrl_i.gcd_step) begin
      if (rem_sh >= gb_q) rem_q <= rem_sh - gb_q;
      else                rem_q <= rem_sh;
      cnt_q <= cnt_q + CW'(1);
    end
    if (ctrl_i.gcd_next) begin
      ga_q  <= gb_q;
      gb_q  <= rem_q;
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (ctrl_i.div_start) begin
      rem_q  <= '0;
      rem2_q <= '0;
      quo_q  <= '0;
      quo2_q <= '0;
      cnt_q  <= '0;
      gb_q   <= ga_q;
      ga_q   <= mag_q;
    end
    if (ctrl_i.div_step) begin
      if (rem_sh >= gb_q) begin
        rem_q <= rem_sh - gb_q;
        quo_q <= {quo_q[WW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[WW-2:0], 1'b0};
      end
      if (rem2_sh >= gb_q) begin
        rem2_q <= rem2_sh - gb_q;
        quo2_q <= {quo2_q[WW-2:0], 1'b1};
      end else begin
        rem2_q <= rem2_sh;
        quo2_q <= {quo2_q[WW-2:0], 1'b0};
      end
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      if (cmd_q > rau_pkg::CmdDiv) begin
        status_q <= rau_pkg::StatOk;
      end else if (err_q) begin
        status_q <= rau_pkg::StatZero;
      end else if (quo_q > lim || quo2_q > lim) begin
        status_q <= rau_pkg::StatOverflow;
      end else begin
        status_q <= rau_pkg::StatOk;
      end
    end
  end

  always_comb begin
    rsp_o.result_num = acc_num_q;
    rsp_o.result_den = acc_den_q;
    rsp_o.status     = status_q;
  end
endmodule

@@ rtl/rau_ctrl.sv @@
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer for the rational accumulator unit
// Runs products, Euclid steps and reduction divisions, then hands the result.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  rau_pkg::stat_t stat_i,
  output rau_pkg::ctrl_t ctrl_o
);
  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StMulA   = 10'b0000000010,
    StMulB   = 10'b0000000100,
    StForm   = 10'b0000001000,
    StGcdChk = 10'b0000010000,
    StGcd    = 10'b0000100000,
    StDivSt  = 10'b0001000000,
    StDiv    = 10'b0010000000,
    StCommit = 10'b0100000000,
    StOut    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = StMulA;
        end
      end
      StMulA: begin
        ctrl_o.mul_a = 1'b1;
        state_d = stat_i.skip ? StCommit : StMulB;
      end
      StMulB: begin
        ctrl_o.mul_b = 1'b1;
        state_d = StForm;
      end
      StForm: begin
        ctrl_o.form = 1'b1;
        state_d = StGcdChk;
      end
      StGcdChk: state_d = stat_i.gcd_done ? StDivSt : StGcd;
      StGcd: begin
        if (stat_i.mod_done) begin
          ctrl_o.gcd_next = 1'b1;
          state_d = StGcdChk;
        end else begin
          ctrl_o.gcd_step = 1'b1;
        end
      end
      StDivSt: begin
        ctrl_o.div_start = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        if (stat_i.div_done) state_d = StCommit;
        else ctrl_o.div_step = 1'b1;
      end
      StCommit: begin
        ctrl_o.commit = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ rtl/rational_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// rational_accumulator_unit: rational accumulator with exact reduction
// Holds a fraction in lowest terms; each valid request loads or combines an operand.
// ----------------------------------------------------------------------------
// Usage:
//   A request (cmd, operand_num, operand_den) is taken when in_valid_i is high
//   and in_stall_o is low. Exactly one response follows for every request,
//   carrying the fraction held afterwards and a status code.
//   The response is held on out_rsp_o with out_valid_o high until a cycle in
//   which out_stall_i is low; no new request is taken meanwhile.
//   The MulA, MulB and Form states form the products; each Euclid step runs
//   a check, a bit-serial modulo and a swap; then a final check, a start
//   state, a reduction pass and the commit precede out_valid_o. Error and
//   no-op requests go from the first product state straight to the commit.
//   One request is processed at a time; the next request can be taken in
//   the cycle after the response handoff.
//   Reset sets the accumulator to 1/1 and empties the response stage.
// ----------------------------------------------------------------------------
module rational_accumulator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rau_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rau_pkg::rsp_t out_rsp_o
);
  rau_pkg::ctrl_t ctrl;
  rau_pkg::stat_t stat;

  rau_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .rsp_o  (out_rsp_o)
  );

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("request taken while response pending");
  a_den_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.result_den != '0) else $error("zero denominator held");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed under stall");
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rational_accumulator_unit
// Directed and random requests go through a queue into a clocked driver. Each
// accepted request updates a local fraction predictor, and the monitor checks
// every response against it field by field. Both sides idle at random, and
// once the receiver holds off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  WatchLimit = 60000;
  localparam int  HoldStart  = 40000;
  localparam int  HoldLen    = 3000;
  localparam logic signed [31:0] NumMax = 32'sh7fffffff;
  localparam logic signed [31:0] NumMin = 32'sh80000000;
  localparam logic [30:0]        DenMax = 31'h7fffffff;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  rau_pkg::req_t in_req;
  rau_pkg::rsp_t out_rsp;

  rau_pkg::req_t pending_q[$];
  rau_pkg::rsp_t fraction_q[$];
  longint acc_num = 1, acc_den = 1;
  int errors, cyc, rx_cyc, idle_cyc, n_sent, n_done, n_err_stat;
  bit stim_done;

  rational_accumulator_unit u_top (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_req_i(in_req), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_rsp_o(out_rsp)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic rau_pkg::status_e fraction_commit(longint n, longint d);
    longint unsigned mag, den, g, t, y;
    bit neg;
    neg = n < 0;
    mag = neg ? -n : n;
    den = d;
    g = mag; y = den;
    while (y != 0) begin
      t = g % y; g = y; y = t;
    end
    mag = mag / g;
    den = den / g;
    if (mag > 64'h7fffffff || den > 64'h7fffffff) return rau_pkg::StatOverflow;
    acc_num = neg ? -longint'(mag) : longint'(mag);
    acc_den = den;
    return rau_pkg::StatOk;
  endfunction

  function automatic rau_pkg::rsp_t fraction_apply(rau_pkg::req_t r);
    longint a, b, c, d;
    rau_pkg::status_e st;
    rau_pkg::rsp_t o;
    a = acc_num; b = acc_den;
    c = longint'(r.operand_num);
    d = longint'({33'd0, r.operand_den});
    st = rau_pkg::StatOk;
    if (r.cmd <= rau_pkg::CmdDiv) begin
      if (d == 0) st = rau_pkg::StatZero;
      else case (rau_pkg::cmd_e'(r.cmd))
        rau_pkg::CmdLoad: st = fraction_commit(c, d);
        rau_pkg::CmdAdd:  st = fraction_commit(a * d + c * b, b * d);
        rau_pkg::CmdSub:  st = fraction_commit(a * d - c * b, b * d);
        rau_pkg::CmdMul:  st = fraction_commit(a * c, b * d);
        default: begin
          if (c == 0) st = rau_pkg::StatZero;
          else if (c < 0) st = fraction_commit(-(a * d), -(b * c));
          else st = fraction_commit(a * d, b * c);
        end
      endcase
    end
    o.result_num = acc_num[31:0];
    o.result_den = acc_den[30:0];
    o.status = st;
    return o;
  endfunction

  function automatic bit quiet_phase();
    return (cyc % 25000) < 6000;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_req <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        fraction_q.push_back(fraction_apply(in_req));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && (quiet_phase() || $urandom_range(99) >= 33)) begin
          in_valid <= 1'b1;
          in_req <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_cyc = 0;
    end else begin
      rx_cyc++;
      if (out_valid && !out_stall) begin
        if (fraction_q.size() == 0) begin
          $display("%0t: unexpected response got %h", $time, out_rsp);
          errors++;
        end else begin
          rau_pkg::rsp_t e;
          e = fraction_q.pop_front();
          n_done++;
          if (e.status != rau_pkg::StatOk) n_err_stat++;
          if (out_rsp.result_num !== e.result_num)
            $display("%0t: result_num expected %0d got %0d", $time, e.result_num,
                     out_rsp.result_num);
          if (out_rsp.result_den !== e.result_den)
            $display("%0t: result_den expected %0d got %0d", $time, e.result_den,
                     out_rsp.result_den);
          if (out_rsp.status !== e.status)
            $display("%0t: status expected %0d got %0d", $time, e.status,
                     out_rsp.status);
          if (out_rsp !== e) errors++;
        end
      end
      if (rx_cyc >= HoldStart && rx_cyc < HoldStart + HoldLen) out_stall <= 1'b1;
      else out_stall <= !quiet_phase() && ($urandom_range(99) < 33);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      cyc++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= WatchLimit) begin
        $display("%0t: timeout, no progress", $time);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic rau_pkg::req_t mk(rau_pkg::cmd_e c, logic signed [31:0] n,
                                       logic [30:0] d);
    rau_pkg::req_t r;
    r.cmd = c; r.operand_num = n; r.operand_den = d;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_num();
    logic signed [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $signed($urandom_range(2000)) - 1000;
      default: v = $signed($urandom_range(200)) - 100;
    endcase
    return v;
  endfunction

  function automatic logic [30:0] rand_den();
    logic [30:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = 31'($urandom);
      2, 3: v = 31'($urandom_range(2000));
      default: v = 31'($urandom_range(60) + 1);
    endcase
    return v;
  endfunction

  initial begin
    rau_pkg::req_t r;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    pending_q.push_back(mk(rau_pkg::CmdAdd, 32'sd1, 31'd2));
    pending_q.push_back(mk(rau_pkg::CmdLoad, NumMax, 31'd1));
    pending_q.push_back(mk(rau_pkg::CmdLoad, NumMin, 31'd1));
    pending_q.push_back(mk(rau_pkg::CmdLoad, NumMin, 31'd2));
    pending_q.push_back(mk(rau_pkg::CmdLoad, 32'sd5, DenMax));
    pending_q.push_back(mk(rau_pkg::CmdLoad, 32'sd3, 31'd0));
    pending_q.push_back(mk(rau_pkg::CmdDiv, 32'sd0, 31'd7));
    pending_q.push_back(mk(rau_pkg::CmdLoad, -32'sd6, 31'd4));
    pending_q.push_back(mk(rau_pkg::CmdSub, -32'sd3, 31'd2));
    pending_q.push_back(mk(rau_pkg::CmdLoad, 32'sd7, 31'd3));
    pending_q.push_back(mk(rau_pkg::CmdMul, -32'sd9, 31'd14));
    pending_q.push_back(mk(rau_pkg::CmdDiv, -32'sd5, 31'd8));
    pending_q.push_back(mk(rau_pkg::CmdAdd, NumMax, DenMax));
    pending_q.push_back(mk(rau_pkg::CmdMul, NumMax, 31'd1));
    pending_q.push_back(mk(rau_pkg::CmdMul, NumMax, 31'd1));
    pending_q.push_back(mk(rau_pkg::CmdDiv, 32'sd1, DenMax));
    pending_q.push_back(mk(rau_pkg::cmd_e'(3'd5), 32'sd1, 31'd1));
    pending_q.push_back(mk(rau_pkg::cmd_e'(3'd6), NumMin, 31'd0));
    pending_q.push_back(mk(rau_pkg::cmd_e'(3'd7), -32'sd1, DenMax));
    pending_q.push_back(mk(rau_pkg::CmdLoad, 32'sd0, 31'd9));
    pending_q.push_back(mk(rau_pkg::CmdLoad, -32'sd1, 31'd1));
    for (int i = 0; i < 1100; i++) begin
      r.cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                        : 3'($urandom_range(4));
      r.operand_num = rand_num();
      r.operand_den = rand_den();
      if ($urandom_range(9) == 0) r.cmd = rau_pkg::CmdLoad;
      pending_q.push_back(r);
    end
    wait (pending_q.size() == 0 && !in_valid && fraction_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("Checked %0d responses to %0d requests, %0d with error status.",
             n_done, n_sent, n_err_stat);
    if (errors == 0 && fraction_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
